/* hdl/lockset_race_detector_defines.svh */
// Assertion macros shared by the lockset race detector RTL.
// Depends on: a clock named clk and an active-low reset named arst_n in scope.
`ifndef LOCKSET_RACE_DETECTOR_DEFINES_SVH
`define LOCKSET_RACE_DETECTOR_DEFINES_SVH

// Combinational invariant, checked at every clock edge out of reset.
`define LRD_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Implication from a trigger to a condition in the same cycle.
`define LRD_ASSERT_IMPL(lbl, trig, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (expr)) else $error(msg);

`endif

/* hdl/lrd_pkg.sv */
// Types and constants of the lockset race detector.
// Depends on: nothing.
package lrd_pkg;

	localparam int LOCK_SLOTS = 16;
	localparam int VAR_SLOTS  = 64;
	localparam int LIDX_W     = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
	localparam int VIDX_W     = (VAR_SLOTS > 1) ? $clog2(VAR_SLOTS) : 1;
	localparam int VCNT_W     = VIDX_W + 1;
	localparam int ADDR_W     = 64;
	localparam int LINE_W     = 32;
	localparam int CMD_W      = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_ACQUIRE = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_ACCESS  = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_code_t;

	typedef struct packed {
		logic [ADDR_W-1:0]     addr;
		logic [LOCK_SLOTS-1:0] cand;
		logic                  rep;
	} var_entry_t;

	localparam int VENTRY_W = $bits(var_entry_t);

	typedef struct packed {
		logic capture;
		logic lock_op;
		logic scan_step;
		logic var_update;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic in_is_lock;
		logic in_is_access;
		logic scan_done;
		logic out_free;
	} dp_status_t;

endpackage

/* hdl/lockset_race_detector.sv */
// Top level of the lockset race detector: controller plus datapath.
// Depends on: lrd_pkg, lrd_ctrl, lrd_dp.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  in      | input     | in_valid / in_stall    | cmd, address, source_line
//  out     | output    | out_valid / out_stall  | race_found, race_line, race_address,
//          |           |                        | lock_table_full, var_table_full
//
// One item is worked at a time; every item gives exactly one result item.
// Acquire and release: capture, lock table update, then the result; unused code: capture, then the result.
// Access: the variable table RAM is scanned one entry per cycle with a
// registered read until a hit or the last entry, then the found or a free entry is written, then the result.
// Reset clears used bits and the held mask; no clearing pass is needed.
// in_stall is high while an item is in work; a held result stalls only the
// finish of the next item, which is accepted and worked meanwhile.
module lockset_race_detector (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [lrd_pkg::CMD_W-1:0]  cmd,
	input  logic [lrd_pkg::ADDR_W-1:0] address,
	input  logic [lrd_pkg::LINE_W-1:0] source_line,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       race_found,
	output logic [lrd_pkg::LINE_W-1:0] race_line,
	output logic [lrd_pkg::ADDR_W-1:0] race_address,
	output logic                       lock_table_full,
	output logic                       var_table_full
);
	import lrd_pkg::*;

	ctrl_cmd_t  ctl;
	dp_status_t status;
	logic       idle;

	// controller sequences capture, lock update, table scan, write back, result
	lrd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.status  (status),
		.ctl     (ctl),
		.idle    (idle)
	);

	// accept only in idle
	assign in_stall = !idle;

	lrd_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.address        (address),
		.source_line    (source_line),
		.ctl            (ctl),
		.status         (status),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.race_found     (race_found),
		.race_line      (race_line),
		.race_address   (race_address),
		.lock_table_full(lock_table_full),
		.var_table_full (var_table_full)
	);
endmodule

/* hdl/lrd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on: nothing.
module lrd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* hdl/lrd_ctrl.sv */
// Controller state machine of the lockset race detector.
// Depends on: lrd_pkg.
module lrd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  lrd_pkg::dp_status_t status,
	output lrd_pkg::ctrl_cmd_t  ctl,
	output logic               idle
);
	import lrd_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOCK = 5'b00010,
		ST_SCAN = 5'b00100,
		ST_UPD  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.capture = 1'b1;
					priority if (status.in_is_lock) state_d = ST_LOCK;
					else if (status.in_is_access)   state_d = ST_SCAN;
					else                            state_d = ST_DONE;
				end
			end
			ST_LOCK: begin
				ctl.lock_op = 1'b1;
				state_d     = ST_DONE;
			end
			ST_SCAN: begin
				ctl.scan_step = 1'b1;
				if (status.scan_done) state_d = ST_UPD;
			end
			ST_UPD: begin
				ctl.var_update = 1'b1;
				state_d        = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	assign idle = (state_q == ST_IDLE);
endmodule

/* hdl/lrd_dp.sv */
// Datapath: lock table, held mask, variable table search and update, result register.
// Depends on: lrd_pkg, lrd_ram, lockset_race_detector_defines.svh.
`include "lockset_race_detector_defines.svh"

module lrd_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [lrd_pkg::CMD_W-1:0]  cmd,
	input  logic [lrd_pkg::ADDR_W-1:0] address,
	input  logic [lrd_pkg::LINE_W-1:0] source_line,
	input  lrd_pkg::ctrl_cmd_t         ctl,
	output lrd_pkg::dp_status_t        status,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       race_found,
	output logic [lrd_pkg::LINE_W-1:0] race_line,
	output logic [lrd_pkg::ADDR_W-1:0] race_address,
	output logic                       lock_table_full,
	output logic                       var_table_full
);
	import lrd_pkg::*;

	// captured item
	cmd_code_t         cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LINE_W-1:0] line_q;

	// lock table
	logic [ADDR_W-1:0]     lock_addr_q [LOCK_SLOTS];
	logic [LOCK_SLOTS-1:0] lock_used_q;
	logic [LOCK_SLOTS-1:0] held_q;
	logic                  lhit, lfree;
	logic [LIDX_W-1:0]     lhit_idx, lfree_idx;

	// variable table
	logic [VAR_SLOTS-1:0] var_used_q;
	logic [VCNT_W-1:0]    rd_ptr_q;
	logic                 cmp_vld_q;
	logic [VIDX_W-1:0]    cmp_ptr_q;
	logic                 free_found_q;
	logic [VIDX_W-1:0]    free_slot_q;
	logic                 hit_q;
	logic [VIDX_W-1:0]    slot_q;
	logic [LOCK_SLOTS-1:0] old_cand_q;
	logic                 old_rep_q;
	logic                 issue, scan_hit, scan_done;
	logic [VIDX_W-1:0]    rd_idx;
	logic [VENTRY_W-1:0]  rdata_raw;
	var_entry_t           rdata, wentry;
	logic                 ram_we;
	logic [LOCK_SLOTS-1:0] cand_new;
	logic                 rep_old, race;

	// pending result
	logic res_race_q, res_lfull_q, res_vfull_q;

	always_comb begin
		lhit      = 1'b0;
		lfree     = 1'b0;
		lhit_idx  = '0;
		lfree_idx = '0;
		for (int i = LOCK_SLOTS - 1; i >= 0; i--) begin
			if (lock_used_q[i] && (lock_addr_q[i] == addr_q)) begin
				lhit     = 1'b1;
				lhit_idx = LIDX_W'(i);
			end
			if (!lock_used_q[i]) begin
				lfree     = 1'b1;
				lfree_idx = LIDX_W'(i);
			end
		end
	end

	assign rd_idx    = rd_ptr_q[VIDX_W-1:0];
	assign issue     = ctl.scan_step && (rd_ptr_q < VCNT_W'(VAR_SLOTS));
	assign rdata     = var_entry_t'(rdata_raw);
	assign scan_hit  = cmp_vld_q && var_used_q[cmp_ptr_q] && (rdata.addr == addr_q);
	assign scan_done = scan_hit || (cmp_vld_q && (cmp_ptr_q == VIDX_W'(VAR_SLOTS - 1)));

	assign cand_new = (hit_q ? old_cand_q : '1) & held_q;
	assign rep_old  = hit_q & old_rep_q;
	assign race     = (cand_new == '0) && !rep_old;
	assign ram_we   = ctl.var_update && (hit_q || free_found_q);
	assign wentry   = '{addr: addr_q, cand: cand_new, rep: rep_old | race};

	lrd_ram #(.WIDTH(VENTRY_W), .DEPTH(VAR_SLOTS)) u_var_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_q),
		.wdata(wentry),
		.re   (issue),
		.raddr(rd_idx),
		.rdata(rdata_raw)
	);

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q  <= cmd_code_t'(cmd);
			addr_q <= address;
			line_q <= source_line;
		end
		if (ctl.lock_op && (cmd_q == CMD_ACQUIRE) && !lhit && lfree) begin
			lock_addr_q[lfree_idx] <= addr_q;
		end
		if (ctl.scan_step) begin
			cmp_ptr_q <= rd_idx;
			if (issue && !free_found_q && !var_used_q[rd_idx]) free_slot_q <= rd_idx;
			if (scan_hit) begin
				slot_q     <= cmp_ptr_q;
				old_cand_q <= rdata.cand;
				old_rep_q  <= rdata.rep;
			end else if (scan_done) begin
				slot_q <= free_slot_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_used_q  <= '0;
			held_q       <= '0;
			var_used_q   <= '0;
			rd_ptr_q     <= '0;
			cmp_vld_q    <= 1'b0;
			free_found_q <= 1'b0;
			hit_q        <= 1'b0;
			res_race_q   <= 1'b0;
			res_lfull_q  <= 1'b0;
			res_vfull_q  <= 1'b0;
		end else begin
			if (ctl.capture) begin
				rd_ptr_q     <= '0;
				cmp_vld_q    <= 1'b0;
				free_found_q <= 1'b0;
				res_race_q   <= 1'b0;
				res_lfull_q  <= 1'b0;
				res_vfull_q  <= 1'b0;
			end
			if (ctl.lock_op) begin
				unique case (cmd_q)
					CMD_ACQUIRE: begin
						priority if (lhit) held_q[lhit_idx] <= 1'b1;
						else if (lfree) begin
							lock_used_q[lfree_idx] <= 1'b1;
							held_q[lfree_idx]      <= 1'b1;
						end else res_lfull_q <= 1'b1;
					end
					CMD_RELEASE: if (lhit) held_q[lhit_idx] <= 1'b0;
					CMD_ACCESS, CMD_NOP: ;
				endcase
			end
			if (ctl.scan_step) begin
				cmp_vld_q <= issue;
				if (issue) begin
					rd_ptr_q <= rd_ptr_q + VCNT_W'(1);
					if (!var_used_q[rd_idx]) free_found_q <= 1'b1;
				end
				if (scan_done) hit_q <= scan_hit;
			end
			if (ctl.var_update) begin
				if (ram_we) begin
					var_used_q[slot_q] <= 1'b1;
					res_race_q         <= race;
				end else begin
					res_vfull_q <= 1'b1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			race_found      <= res_race_q;
			race_line       <= res_race_q ? line_q : '0;
			race_address    <= res_race_q ? addr_q : '0;
			lock_table_full <= res_lfull_q;
			var_table_full  <= res_vfull_q;
		end
	end

	assign status.in_is_lock   = (cmd_code_t'(cmd) == CMD_ACQUIRE) ||
	                             (cmd_code_t'(cmd) == CMD_RELEASE);
	assign status.in_is_access = (cmd_code_t'(cmd) == CMD_ACCESS);
	assign status.scan_done    = scan_done;
	assign status.out_free     = !out_valid || !out_stall;

	`LRD_ASSERT_ALWAYS(a_held_in_used, (held_q & ~lock_used_q) == '0, "held lock has no slot")
	`LRD_ASSERT_IMPL(a_race_not_full, res_race_q, !res_vfull_q && !res_lfull_q, "race with full flag")
	`LRD_ASSERT_IMPL(a_write_slot_ok, ram_we && !hit_q, !var_used_q[slot_q], "alloc into used slot")
endmodule

/* sim/lockset_race_detector_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of lockset_race_detector: directed and random trace events.
// Depends on: lrd_pkg and the lockset_race_detector RTL.
module lockset_race_detector_tb;
	import lrd_pkg::*;

	typedef struct packed {
		logic              found;
		logic [LINE_W-1:0] line;
		logic [ADDR_W-1:0] addr;
		logic              lock_full;
		logic              var_full;
	} verdict_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [CMD_W-1:0]           cmd = '0;
	logic [ADDR_W-1:0]          address = '0;
	logic [LINE_W-1:0]          source_line = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic                       race_found;
	logic [LINE_W-1:0]          race_line;
	logic [ADDR_W-1:0]          race_address;
	logic                       lock_table_full;
	logic                       var_table_full;

	// shadow of the block state
	logic [ADDR_W-1:0]     lk_addr [LOCK_SLOTS];
	logic [LOCK_SLOTS-1:0] lk_used;
	logic [LOCK_SLOTS-1:0] held;
	logic [ADDR_W-1:0]     vr_addr [VAR_SLOTS];
	logic [VAR_SLOTS-1:0]  vr_used;
	logic [LOCK_SLOTS-1:0] vr_cand [VAR_SLOTS];
	logic [VAR_SLOTS-1:0]  vr_rep;

	verdict_t pending_verdicts[$];
	int       errors = 0;
	int       cycles = 0;
	bit       calm = 1'b0;
	bit       stall_on = 1'b1;
	logic [ADDR_W-1:0] lock_pool [24];
	logic [ADDR_W-1:0] var_pool  [80];

	lockset_race_detector u_top (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("lockset_race_detector regression: fail");
			$finish;
		end
	end

	task automatic report(input string what);
		errors++;
		$display("MISMATCH @%0t: %s", $time, what);
	endtask

	// compute the verdict for one trace event and update the shadow state
	function automatic verdict_t predict_event(cmd_code_t c, logic [ADDR_W-1:0] a,
			logic [LINE_W-1:0] ln);
		verdict_t v;
		int hit;
		int fr;
		v = '0;
		hit = -1;
		fr = -1;
		if (c == CMD_ACQUIRE || c == CMD_RELEASE) begin
			for (int i = 0; i < LOCK_SLOTS; i++)
				if (lk_used[i]) begin
					if (lk_addr[i] == a && hit < 0) hit = i;
				end else if (fr < 0) fr = i;
			if (c == CMD_ACQUIRE) begin
				if (hit < 0 && fr < 0) v.lock_full = 1'b1;
				else begin
					if (hit < 0) begin
						hit = fr;
						lk_used[hit] = 1'b1;
						lk_addr[hit] = a;
					end
					held[hit] = 1'b1;
				end
			end else if (hit >= 0) held[hit] = 1'b0;
		end else if (c == CMD_ACCESS) begin
			for (int i = 0; i < VAR_SLOTS; i++)
				if (vr_used[i]) begin
					if (vr_addr[i] == a && hit < 0) hit = i;
				end else if (fr < 0) fr = i;
			if (hit < 0 && fr < 0) v.var_full = 1'b1;
			else begin
				if (hit < 0) begin
					hit = fr;
					vr_used[hit] = 1'b1;
					vr_addr[hit] = a;
					vr_cand[hit] = '1;
					vr_rep[hit] = 1'b0;
				end
				vr_cand[hit] &= held;
				if (vr_cand[hit] == '0 && !vr_rep[hit]) begin
					vr_rep[hit] = 1'b1;
					v.found = 1'b1;
					v.line = ln;
					v.addr = a;
				end
			end
		end
		return v;
	endfunction

	// send one event; gaps before it in random bursts
	task automatic send_event(cmd_code_t c, logic [ADDR_W-1:0] a, logic [LINE_W-1:0] ln);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		cmd <= c;
		address <= a;
		source_line <= ln;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_verdicts.push_back(predict_event(c, a, ln));
		@(negedge clk);
	endtask

	// receiver stall in random bursts
	always begin
		@(negedge clk);
		if (!calm && stall_on && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 9)) @(negedge clk);
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		verdict_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) report("result with none expected");
			else begin
				e = pending_verdicts.pop_front();
				if (race_found !== e.found) report("race_found");
				if (race_line !== e.line) report("race_line");
				if (race_address !== e.addr) report("race_address");
				if (lock_table_full !== e.lock_full) report("lock_table_full");
				if (var_table_full !== e.var_full) report("var_table_full");
			end
		end
	end

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(negedge clk);
	endtask

	// acquire, release, access and unused code at field extremes
	task automatic test_directed();
		send_event(CMD_NOP, '1, '1);
		send_event(CMD_RELEASE, 64'h55, 32'd1);          // unknown lock
		send_event(CMD_ACQUIRE, '1, 32'd2);
		send_event(CMD_ACQUIRE, '1, 32'd3);              // repeated acquire
		send_event(CMD_ACCESS, '0, 32'd4);
		send_event(CMD_RELEASE, '1, 32'd5);
		send_event(CMD_ACCESS, '0, '1);                  // race
		send_event(CMD_ACCESS, '0, 32'd7);               // no second report
		send_event(CMD_ACQUIRE, '0, 32'd8);
		send_event(CMD_ACCESS, '1, 32'd9);
		send_event(CMD_RELEASE, '0, 32'd10);
		send_event(CMD_ACCESS, '1, 32'hAAAA_5555);
		send_event(CMD_ACCESS, 64'hAAAA_5555_AAAA_5555, 32'h5555_AAAA);
		drain();
	endtask

	// fill both tables past capacity
	task automatic test_table_full();
		for (int i = 0; i < LOCK_SLOTS + 2; i++)
			send_event(CMD_ACQUIRE, 64'h1000 + i, i);
		for (int i = 0; i < VAR_SLOTS + 2; i++)
			send_event(CMD_ACCESS, {$urandom, $urandom}, $urandom);
		for (int i = 0; i < LOCK_SLOTS + 2; i++)
			send_event(CMD_RELEASE, 64'h1000 + i, i);
		drain();
	endtask

	// random traces over small address pools
	task automatic test_random(int n);
		cmd_code_t c;
		logic [ADDR_W-1:0] a;
		for (int i = 0; i < n; i++) begin
			if (i == n - 150) calm = 1'b1;
			if (i == n / 2) begin
				stall_on = 1'b0;
				drain();
				stall_on = 1'b1;
			end
			case ($urandom_range(0, 9))
				0, 1, 2: c = CMD_ACQUIRE;
				3, 4, 5: c = CMD_RELEASE;
				9: c = ($urandom_range(0, 4) == 0) ? CMD_NOP : CMD_ACCESS;
				default: c = CMD_ACCESS;
			endcase
			if (c == CMD_ACCESS) a = var_pool[$urandom_range(0, 79)];
			else a = lock_pool[$urandom_range(0, 23)];
			send_event(c, a, $urandom);
		end
		drain();
	endtask

	initial begin
		lk_used = '0;
		held = '0;
		vr_used = '0;
		vr_rep = '0;
		for (int i = 0; i < 24; i++) lock_pool[i] = {$urandom, $urandom};
		for (int i = 0; i < 80; i++) var_pool[i] = {$urandom, $urandom};
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_table_full();
		test_random(1250);
		repeat (100) @(negedge clk);
		if (errors == 0 && pending_verdicts.size() == 0)
			$display("lockset_race_detector regression: pass");
		else
			$display("lockset_race_detector regression: fail");
		$finish;
	end
endmodule
